[rtl/core/foil_sealer_step_sequencer_assert.svh]
// Assertion macros shared by the foil sealer step sequencer RTL.
`ifndef FOIL_SEALER_STEP_SEQUENCER_ASSERT_SVH
`define FOIL_SEALER_STEP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fss assertion failed");

`endif

[rtl/core/fss_pkg.sv]
// Types, codes and constants shared by the foil sealer step sequencer.
package fss_pkg;

    localparam int TIME_W = 32;
    localparam int INTERVAL_W = 20;
    localparam int DUR_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int SUB_MS_W = 10;

    localparam logic [SUB_MS_W-1:0] SUB_MS_LAST = SUB_MS_W'(999);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TENSION = 2'd1;
    localparam logic [1:0] PH_PRESS = 2'd2;
    localparam logic [1:0] PH_PULL = 2'd3;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_STARTED = 3'd1;
    localparam logic [2:0] EV_FLAG = 3'd2;
    localparam logic [2:0] EV_TIMEOUT = 3'd3;
    localparam logic [2:0] EV_PRESS_DONE = 3'd4;
    localparam logic [2:0] EV_PULL_DONE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_TENSION_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULL_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TENSION_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULL_TIME = 3'd4;

    localparam logic [INTERVAL_W-1:0] TENSION_INTERVAL_RESET = INTERVAL_W'(6250);
    localparam logic [INTERVAL_W-1:0] PULL_INTERVAL_RESET = INTERVAL_W'(2205);
    localparam logic [DUR_W-1:0] TENSION_TIMEOUT_RESET = DUR_W'(10000);
    localparam logic [DUR_W-1:0] PRESS_TIME_RESET = DUR_W'(2100);
    localparam logic [DUR_W-1:0] PULL_TIME_RESET = DUR_W'(2000);

    typedef struct packed {
        logic [INTERVAL_W-1:0] tension_interval;
        logic [INTERVAL_W-1:0] pull_interval;
        logic [DUR_W-1:0]      tension_timeout;
        logic [DUR_W-1:0]      press_time;
        logic [DUR_W-1:0]      pull_time;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] us;
        logic [TIME_W-1:0] ms;
    } now_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic       dir_two;
        logic       dir_one;
        logic       step_two;
        logic       step_one;
        logic       motor_two_enabled;
        logic       motor_one_enabled;
        logic [1:0] phase;
    } res_t;

endpackage

[rtl/core/fss_cfg_regs.sv]
// Configuration register file of the foil sealer step sequencer.
module fss_cfg_regs
    import fss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_TENSION_INTERVAL: cfg_next.tension_interval = wr_data[INTERVAL_W-1:0];
                REG_PULL_INTERVAL:    cfg_next.pull_interval = wr_data[INTERVAL_W-1:0];
                REG_TENSION_TIMEOUT:  cfg_next.tension_timeout = wr_data[DUR_W-1:0];
                REG_PRESS_TIME:       cfg_next.press_time = wr_data[DUR_W-1:0];
                REG_PULL_TIME:        cfg_next.pull_time = wr_data[DUR_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tension_interval <= TENSION_INTERVAL_RESET;
            cfg_reg.pull_interval <= PULL_INTERVAL_RESET;
            cfg_reg.tension_timeout <= TENSION_TIMEOUT_RESET;
            cfg_reg.press_time <= PRESS_TIME_RESET;
            cfg_reg.pull_time <= PULL_TIME_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/fss_timebase.sv]
// Wrapping microsecond and millisecond counters advanced once per tick.
module fss_timebase
    import fss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    output now_t now
);

    logic [TIME_W-1:0]   us_reg;
    logic [TIME_W-1:0]   us_next;
    logic [TIME_W-1:0]   ms_reg;
    logic [TIME_W-1:0]   ms_next;
    logic [SUB_MS_W-1:0] sub_ms_reg;
    logic [SUB_MS_W-1:0] sub_ms_next;

    always_comb
    begin
        us_next = us_reg;
        ms_next = ms_reg;
        sub_ms_next = sub_ms_reg;
        if (advance)
        begin
            us_next = us_reg + TIME_W'(1);
            if (sub_ms_reg == SUB_MS_LAST)
            begin
                sub_ms_next = '0;
                ms_next = ms_reg + TIME_W'(1);
            end
            else
            begin
                sub_ms_next = sub_ms_reg + SUB_MS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            us_reg <= '0;
            ms_reg <= '0;
            sub_ms_reg <= '0;
        end
        else
        begin
            us_reg <= us_next;
            ms_reg <= ms_next;
            sub_ms_reg <= sub_ms_next;
        end
    end

    assign now.us = us_reg;
    assign now.ms = ms_reg;

endmodule

[rtl/core/fss_core.sv]
// Phase sequencer: phase state, step timing, driver enables and directions.
module fss_core
    import fss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  logic button,
    input  logic flag,
    input  cfg_t cfg,
    input  now_t now,
    output res_t res
);

`include "foil_sealer_step_sequencer_assert.svh"

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic              btn_mem_reg;
    logic              btn_mem_next;
    logic [TIME_W-1:0] last_one_reg;
    logic [TIME_W-1:0] last_one_next;
    logic [TIME_W-1:0] last_two_reg;
    logic [TIME_W-1:0] last_two_next;
    logic [TIME_W-1:0] start_ms_reg;
    logic [TIME_W-1:0] start_ms_next;
    logic              en_one_reg;
    logic              en_one_next;
    logic              en_two_reg;
    logic              en_two_next;
    logic              dir_one_reg;
    logic              dir_one_next;
    logic              dir_two_reg;
    logic              dir_two_next;

    logic [TIME_W-1:0] el_one;
    logic [TIME_W-1:0] el_two;
    logic [TIME_W-1:0] el_ms;
    logic              s1;
    logic              s2;
    logic [2:0]        ev;

    assign el_one = now.us - last_one_reg;
    assign el_two = now.us - last_two_reg;
    assign el_ms = now.ms - start_ms_reg;

    always_comb
    begin
        phase_next = phase_reg;
        btn_mem_next = btn_mem_reg;
        last_one_next = last_one_reg;
        last_two_next = last_two_reg;
        start_ms_next = start_ms_reg;
        en_one_next = en_one_reg;
        en_two_next = en_two_reg;
        dir_one_next = dir_one_reg;
        dir_two_next = dir_two_reg;
        s1 = 1'b0;
        s2 = 1'b0;
        ev = EV_NONE;
        case (phase_reg)
            PH_IDLE:
            begin
                en_one_next = 1'b0;
                en_two_next = 1'b0;
                if (button && !btn_mem_reg)
                begin
                    phase_next = PH_TENSION;
                    start_ms_next = now.ms;
                    en_one_next = 1'b1;
                    en_two_next = 1'b1;
                    ev = EV_STARTED;
                end
                btn_mem_next = button;
            end
            PH_TENSION:
            begin
                en_one_next = 1'b1;
                if (!flag)
                begin
                    if (el_two >= TIME_W'(cfg.tension_interval))
                    begin
                        last_two_next = now.us;
                        dir_two_next = 1'b0;
                        s2 = 1'b1;
                    end
                    if (el_ms >= TIME_W'(cfg.tension_timeout))
                    begin
                        phase_next = PH_IDLE;
                        ev = EV_TIMEOUT;
                    end
                end
                else
                begin
                    phase_next = PH_PRESS;
                    start_ms_next = now.ms;
                    ev = EV_FLAG;
                end
            end
            PH_PRESS:
            begin
                en_one_next = 1'b1;
                en_two_next = 1'b1;
                if (el_ms >= TIME_W'(cfg.press_time))
                begin
                    phase_next = PH_PULL;
                    start_ms_next = now.ms;
                    ev = EV_PRESS_DONE;
                end
            end
            default:
            begin
                if (el_ms < TIME_W'(cfg.pull_time))
                begin
                    if (el_one >= TIME_W'(cfg.pull_interval))
                    begin
                        last_one_next = now.us;
                        dir_one_next = 1'b1;
                        s1 = 1'b1;
                    end
                    if (el_two >= TIME_W'(cfg.pull_interval))
                    begin
                        last_two_next = now.us;
                        dir_two_next = 1'b1;
                        s2 = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                    ev = EV_PULL_DONE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            btn_mem_reg <= 1'b0;
            last_one_reg <= '0;
            last_two_reg <= '0;
            start_ms_reg <= '0;
            en_one_reg <= 1'b0;
            en_two_reg <= 1'b0;
            dir_one_reg <= 1'b0;
            dir_two_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            btn_mem_reg <= btn_mem_next;
            last_one_reg <= last_one_next;
            last_two_reg <= last_two_next;
            start_ms_reg <= start_ms_next;
            en_one_reg <= en_one_next;
            en_two_reg <= en_two_next;
            dir_one_reg <= dir_one_next;
            dir_two_reg <= dir_two_next;
        end
    end

    assign res.phase = phase_next;
    assign res.motor_one_enabled = en_one_next;
    assign res.motor_two_enabled = en_two_next;
    assign res.step_one = s1;
    assign res.step_two = s2;
    assign res.dir_one = dir_one_next;
    assign res.dir_two = dir_two_next;
    assign res.event_res = ev;

    `FSS_ASSERT_IMPLIES(a_step_one_in_pull, clk, rst_n, fire && s1, phase_reg == PH_PULL)
    `FSS_ASSERT_NEXT(a_start_enters_tension, clk, rst_n, fire && ev == EV_STARTED,
        phase_reg == PH_TENSION && en_one_reg && en_two_reg)
    `FSS_ASSERT_NEXT(a_phase_holds_without_tick, clk, rst_n, !fire, $stable(phase_reg))
    `FSS_ASSERT_NEXT(a_step_two_marks_time, clk, rst_n, fire && s2,
        last_two_reg == $past(now.us))

endmodule

[rtl/core/foil_sealer_step_sequencer.sv]
// Top level of the foil sealer step sequencer: handshakes, input and result registers.
//
// Channel  Direction  Word
// s_       in         tick: button_pressed, flag_sensor
// m_       out        result: phase, enables, step pulses, directions, event_res
// cfg_     in         register write: index and data, always ready
//
// One tick word is taken every cycle when the result side keeps up.
// A tick is held in the input register and its result is captured in the
// output register when the core fires, which a stalled result side delays.
// The phase update and the timebase increment set this rate.
// A stalled result holds the input register, and s_tready falls once it is full.
// Reset clears valid flags, core and timebase state and loads the register defaults.
module foil_sealer_step_sequencer
    import fss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // button_pressed, flag_sensor, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // phase[1:0], motor_one_enabled,
                                             // motor_two_enabled, step_one, step_two,
                                             // dir_one, dir_two, event_res[2:0], zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic in_valid_reg;
    logic in_valid_next;
    logic in_button_reg;
    logic in_flag_reg;
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_res_reg;
    logic fire;
    logic take;
    cfg_t cfg;
    now_t now;
    res_t res;

    assign fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign take = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next = take || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_button_reg <= s_tdata[0];
            in_flag_reg <= s_tdata[1];
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    fss_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fss_timebase u_timebase (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .now     (now)
    );

    fss_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .button (in_button_reg),
        .flag   (in_flag_reg),
        .cfg    (cfg),
        .now    (now),
        .res    (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {5'b0,
                      out_res_reg.event_res,
                      out_res_reg.dir_two,
                      out_res_reg.dir_one,
                      out_res_reg.step_two,
                      out_res_reg.step_one,
                      out_res_reg.motor_two_enabled,
                      out_res_reg.motor_one_enabled,
                      out_res_reg.phase};

endmodule
